>>> rtl/set_assoc_cache_tag_policy_top_macros.svh
`ifndef SET_ASSOC_CACHE_TAG_POLICY_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_POLICY_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SACTP_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sactp check failed");

// next-cycle implication, checked outside reset
`define SACTP_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sactp check failed");

`endif

>>> rtl/sactp_pkg.sv
`default_nettype none
package sactp_pkg;
	localparam int MAX_SETS   = 256;
	localparam int MAX_WAYS   = 8;
	localparam int SET_W      = 8;
	localparam int WAY_W      = 3;
	localparam int TAG_W      = 30;
	localparam int STAMP_W    = 32;
	localparam int TOTAL_W    = 40;
	localparam int CLR_W      = SET_W + 1;

	localparam logic [6:0]  STORE_COST = 7'd100;
	localparam logic [6:0]  BASE_COST  = 7'd1;
	localparam logic [15:0] LFSR_MASK  = 16'hB400;
	localparam logic [15:0] LFSR_SEED  = 16'h0001;

	localparam logic [2:0] CFG_SET_BITS  = 3'd0;
	localparam logic [2:0] CFG_OFF_BITS  = 3'd1;
	localparam logic [2:0] CFG_WAYS      = 3'd2;
	localparam logic [2:0] CFG_WR_THRU   = 3'd3;
	localparam logic [2:0] CFG_WR_ALLOC  = 3'd4;
	localparam logic [2:0] CFG_REPL_MODE = 3'd5;

	localparam logic [1:0] REPL_LRU  = 2'd0;
	localparam logic [1:0] REPL_FIFO = 2'd1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clr_we;
		logic accept;
		logic eval;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_blocked;
	} dp_sts_t;
endpackage
`default_nettype wire

>>> rtl/sactp_dp.sv
`default_nettype none
module sactp_dp import sactp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctrl_cmd_t          cmd,
	output dp_sts_t                 sts,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [3:0]         cfg_data,
	input  wire logic               op,
	input  wire logic [31:0]        address,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              outcome,
	output logic [6:0]              cycles_added,
	output logic                    line_filled,
	output logic [2:0]              way_used,
	output logic [TOTAL_W-1:0]      cycle_total
);
	logic [3:0] set_bits_q, off_bits_q, ways_q;
	logic       wt_q, wa_q;
	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 4'd0;
			off_bits_q <= 4'd2;
			ways_q     <= 4'd1;
			wt_q       <= 1'b1;
			wa_q       <= 1'b1;
			mode_q     <= REPL_LRU;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:  set_bits_q <= cfg_data;
				CFG_OFF_BITS:  off_bits_q <= cfg_data;
				CFG_WAYS:      ways_q     <= cfg_data;
				CFG_WR_THRU:   wt_q       <= cfg_data[0];
				CFG_WR_ALLOC:  wa_q       <= cfg_data[0];
				CFG_REPL_MODE: mode_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [3:0]       s_eff, b_eff, ways_eff;
	logic [MAX_WAYS-1:0] way_mask;
	logic [4:0]       sb;
	logic [31:0]      addr_sh;
	logic [SET_W-1:0] set_msk, set_in;
	logic [TAG_W-1:0] tag_in;

	always_comb begin
		s_eff = (set_bits_q > 4'd8) ? 4'd8 : set_bits_q;
		b_eff = (off_bits_q < 4'd2) ? 4'd2 : ((off_bits_q > 4'd12) ? 4'd12 : off_bits_q);
		if (ways_q >= 4'd8)      ways_eff = 4'd8;
		else if (ways_q >= 4'd4) ways_eff = 4'd4;
		else if (ways_q >= 4'd2) ways_eff = 4'd2;
		else                     ways_eff = 4'd1;
		for (int i = 0; i < MAX_WAYS; i++)
			way_mask[i] = (4'(i) < ways_eff);
		sb      = 5'(s_eff) + 5'(b_eff);
		addr_sh = address >> b_eff;
		set_msk = SET_W'((9'd1 << s_eff) - 9'd1);
		set_in  = addr_sh[SET_W-1:0] & set_msk;
		tag_in  = TAG_W'(address >> sb);
	end

	// set memories, one row per set
	logic [TAG_W-1:0]   tag_mem [MAX_SETS][MAX_WAYS];
	logic [STAMP_W-1:0] lu_mem  [MAX_SETS][MAX_WAYS];
	logic [STAMP_W-1:0] fs_mem  [MAX_SETS][MAX_WAYS];
	logic [MAX_WAYS-1:0] vld_mem [MAX_SETS];

	logic [TAG_W-1:0]    tag_rd_s1 [MAX_WAYS];
	logic [STAMP_W-1:0]  lu_rd_s1  [MAX_WAYS];
	logic [STAMP_W-1:0]  fs_rd_s1  [MAX_WAYS];
	logic [MAX_WAYS-1:0] vld_rd_s1;
	logic                op_s1;
	logic [SET_W-1:0]    set_s1;
	logic [TAG_W-1:0]    tag_s1;

	logic [CLR_W-1:0]   clr_cnt_q;
	logic [STAMP_W-1:0] acc_q;
	logic [15:0]        lfsr_q;
	logic [TOTAL_W-1:0] total_q;

	// evaluation
	logic [MAX_WAYS-1:0] hit_vec, free_vec;
	logic                hit, any_free, alloc;
	logic [WAY_W-1:0]    hit_way, free_way, old_way, way_sel;
	logic [STAMP_W-1:0]  age [MAX_WAYS];
	logic [STAMP_W-1:0]  a1 [4];
	logic [WAY_W-1:0]    i1 [4];
	logic [STAMP_W-1:0]  a2 [2];
	logic [WAY_W-1:0]    i2 [2];
	logic [15:0]         lfsr_nx;
	logic                rand_ev;
	logic [2:0]          way_msk3;

	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			hit_vec[i]  = vld_rd_s1[i] & way_mask[i] & (tag_rd_s1[i] == tag_s1);
			free_vec[i] = ~vld_rd_s1[i] & way_mask[i];
			if (hit_vec[i])  hit_way  = WAY_W'(i);
			if (free_vec[i]) free_way = WAY_W'(i);
			// ineligible ways age zero; they sit to the right so never win a tie
			age[i] = way_mask[i] ?
				(acc_q - ((mode_q == REPL_LRU) ? lu_rd_s1[i] : fs_rd_s1[i])) : '0;
		end
		hit      = |hit_vec;
		any_free = |free_vec;
		for (int j = 0; j < 4; j++) begin
			if (age[2*j+1] > age[2*j]) begin
				a1[j] = age[2*j+1]; i1[j] = WAY_W'(2*j+1);
			end else begin
				a1[j] = age[2*j];   i1[j] = WAY_W'(2*j);
			end
		end
		for (int j = 0; j < 2; j++) begin
			if (a1[2*j+1] > a1[2*j]) begin
				a2[j] = a1[2*j+1]; i2[j] = i1[2*j+1];
			end else begin
				a2[j] = a1[2*j];   i2[j] = i1[2*j];
			end
		end
		old_way  = (a2[1] > a2[0]) ? i2[1] : i2[0];
		lfsr_nx  = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
		way_msk3 = 3'(ways_eff - 4'd1);
		alloc    = !op_s1 || wa_q;
		rand_ev  = 1'b0;
		if (hit)
			way_sel = hit_way;
		else if (any_free)
			way_sel = free_way;
		else if (mode_q == REPL_LRU || mode_q == REPL_FIFO)
			way_sel = old_way;
		else begin
			way_sel = lfsr_nx[2:0] & way_msk3;
			rand_ev = alloc;
		end
	end

	logic             hit_s2, alloc_s2, rand_s2;
	logic [WAY_W-1:0] way_s2;
	logic [15:0]      lfsr_s2;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1  <= op;
			set_s1 <= set_in;
			tag_s1 <= tag_in;
			for (int i = 0; i < MAX_WAYS; i++) begin
				tag_rd_s1[i] <= tag_mem[set_in][i];
				lu_rd_s1[i]  <= lu_mem[set_in][i];
				fs_rd_s1[i]  <= fs_mem[set_in][i];
			end
			vld_rd_s1 <= vld_mem[set_in];
		end
		if (cmd.eval) begin
			hit_s2   <= hit;
			alloc_s2 <= alloc;
			rand_s2  <= rand_ev;
			way_s2   <= way_sel;
			lfsr_s2  <= lfsr_nx;
		end
	end

	logic fill;
	assign fill = !hit_s2 && alloc_s2;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (fill) begin
				tag_mem[set_s1][way_s2] <= tag_s1;
				fs_mem[set_s1][way_s2]  <= acc_q;
			end
			if (hit_s2 || fill)
				lu_mem[set_s1][way_s2] <= acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we)
			vld_mem[clr_cnt_q[SET_W-1:0]] <= '0;
		else if (cmd.commit && fill)
			vld_mem[set_s1] <= vld_rd_s1 | (MAX_WAYS'(1) << way_s2);
	end

	logic [6:0] cost;
	assign cost = (op_s1 && (hit_s2 ? wt_q : !wa_q)) ? STORE_COST : BASE_COST;

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			acc_q       <= '0;
			lfsr_q      <= LFSR_SEED;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_we)
				clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			if (cmd.commit) begin
				acc_q       <= acc_q + STAMP_W'(1);
				total_q     <= total_q + TOTAL_W'(cost);
				out_valid_q <= 1'b1;
				if (rand_s2)
					lfsr_q <= lfsr_s2;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			outcome      <= {op_s1, !hit_s2};
			cycles_added <= cost;
			line_filled  <= fill;
			way_used     <= (hit_s2 || fill) ? way_s2 : '0;
			cycle_total  <= total_q + TOTAL_W'(cost);
		end
	end

	assign out_valid = out_valid_q;
	assign sts       = '{clr_done: clr_cnt_q[CLR_W-1], out_blocked: out_valid_q && out_stall};
endmodule
`default_nettype wire

>>> rtl/sactp_ctrl.sv
`default_nettype none
`include "set_assoc_cache_tag_policy_top_macros.svh"
module sactp_ctrl import sactp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire dp_sts_t sts,
	output ctrl_cmd_t    cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = !sts.clr_done;
				if (sts.clr_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.commit = !sts.out_blocked;
				if (!sts.out_blocked)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	`SACTP_NEXT(a_accept_to_eval, cmd.accept, state_q == ST_EVAL)
	`SACTP_NEXT(a_eval_to_write, state_q == ST_EVAL, state_q == ST_WRITE)
	`SACTP_IMPL(a_commit_has_room, cmd.commit, !sts.out_blocked)
	`SACTP_IMPL(a_no_accept_in_clear, cmd.clr_we, !cmd.accept && !cmd.commit)
endmodule
`default_nettype wire

>>> rtl/set_assoc_cache_tag_policy_top.sv
// Set-associative cache tag lookup with LRU, FIFO or random replacement.
// Input channel: in_valid/in_stall with op (0 load, 1 store) and a 32-bit
// address. Output channel: out_valid/out_stall with outcome, cycles_added,
// line_filled, way_used and the running cycle_total.
// Config: cfg_we writes cfg_data into register cfg_index (0 set bits,
// 1 offset bits, 2 ways, 3 write-through, 4 write-allocate, 5 replace mode);
// write only while no access is in flight.
// Each access passes through accept and set-row read, tag compare with
// victim choice, then row write-back and result registered. A new access is
// taken only once the controller is back in idle after the write-back.
// out_valid rises at the write-back edge, as the result registers load.
// After reset the valid bits are swept clear, one set per cycle, and
// in_stall stays high until all 256 sets are done. A stalled result holds
// in the output register; a following access may be accepted but will not
// finish until the previous result is taken.
`default_nettype none
module set_assoc_cache_tag_policy_top import sactp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [3:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic [31:0]        address,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              outcome,
	output logic [6:0]              cycles_added,
	output logic                    line_filled,
	output logic [2:0]              way_used,
	output logic [TOTAL_W-1:0]      cycle_total
);
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	sactp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sactp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.address      (address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.outcome      (outcome),
		.cycles_added (cycles_added),
		.line_filled  (line_filled),
		.way_used     (way_used),
		.cycle_total  (cycle_total)
	);
endmodule
`default_nettype wire
